>>> hdl/rlpse_pkg.sv
package rlpse_pkg;

	localparam int LEN_BYTES_DEFAULT = 4;
	localparam int QUEUE_DEPTH       = 4;

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 8;
	localparam int OP_W        = 2;

	localparam logic [7:0] STRING_BASE = 8'h80;
	localparam logic [7:0] LIST_BASE   = 8'hc0;
	localparam int         SHORT_LIMIT = 56;
	localparam logic [7:0] LONG_OFFSET = 8'd55;

	typedef enum logic [OP_W-1:0] {
		OP_STRING  = 2'd0,
		OP_LIST    = 2'd1,
		OP_PAYLOAD = 2'd2
	} op_t;

	// lead byte of a command and how its tail ends
	typedef struct packed {
		logic [7:0] head;
		logic       head_end;
		logic       head_err;
		logic       tail_end;
	} cmd_ctrl_t;

endpackage

>>> hdl/rlpse_front.sv
module rlpse_front #(
	parameter int LEN_BYTES = rlpse_pkg::LEN_BYTES_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [rlpse_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  logic [rlpse_pkg::OP_W-1:0]          s_tuser,
	input  logic                                q_full,
	output logic                                push,
	output rlpse_pkg::cmd_ctrl_t                cmd_ctrl,
	output logic [$clog2(LEN_BYTES+1)-1:0]      cmd_cnt,
	output logic [LEN_BYTES-1:0][7:0]           cmd_word
);

	localparam int LEN_W = 8 * LEN_BYTES;
	localparam int CNT_W = $clog2(LEN_BYTES + 1);
	localparam int EXT_W = (LEN_W > 32) ? LEN_W : 32;

	logic [LEN_W-1:0] rem_q, rem_d;
	logic             open_q, open_d;
	logic             pend_q, pend_d;

	rlpse_pkg::op_t   op;
	logic [EXT_W-1:0] len_ext;
	logic [LEN_W-1:0] len;
	logic [LEN_W-1:0] rem_dec;
	logic [7:0]       data;
	logic [7:0]       base;
	logic [CNT_W-1:0] n_len;
	logic             accept;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign op       = rlpse_pkg::op_t'(s_tuser);
	assign len_ext  = EXT_W'(s_tdata[31:0]);
	assign len      = len_ext[LEN_W-1:0];
	assign data     = s_tdata[39:32];
	assign rem_dec  = rem_q - LEN_W'(1);
	assign base     = (op == rlpse_pkg::OP_LIST) ? rlpse_pkg::LIST_BASE
	                                            : rlpse_pkg::STRING_BASE;

	// minimal big-endian byte count of the length
	always_comb begin
		n_len = '0;
		for (int i = 0; i < LEN_BYTES; i++) begin
			if (len[i*8 +: 8] != 8'd0) n_len = CNT_W'(i + 1);
		end
	end

	always_comb begin
		push     = 1'b0;
		cmd_ctrl = '0;
		cmd_cnt  = '0;
		cmd_word = '0;
		rem_d    = rem_q;
		open_d   = open_q;
		pend_d   = pend_q;
		if (accept) begin
			case (op)
				rlpse_pkg::OP_STRING, rlpse_pkg::OP_LIST: begin
					rem_d  = len;
					open_d = 1'b1;
					pend_d = 1'b0;
					if (len == '0) begin
						push              = 1'b1;
						cmd_ctrl.head     = base;
						cmd_ctrl.head_end = 1'b1;
						open_d            = 1'b0;
					end else if (op == rlpse_pkg::OP_STRING && len == LEN_W'(1)) begin
						// prefix depends on the byte itself
						pend_d = 1'b1;
					end else if (len < LEN_W'(rlpse_pkg::SHORT_LIMIT)) begin
						push          = 1'b1;
						cmd_ctrl.head = base + len[7:0];
					end else begin
						push          = 1'b1;
						cmd_ctrl.head = base + rlpse_pkg::LONG_OFFSET + 8'(n_len);
						cmd_cnt       = n_len;
						cmd_word      = len;
					end
				end
				rlpse_pkg::OP_PAYLOAD: begin
					push = 1'b1;
					if (!open_q) begin
						cmd_ctrl.head_err = 1'b1;
					end else if (pend_q) begin
						pend_d = 1'b0;
						open_d = 1'b0;
						rem_d  = '0;
						if (data < rlpse_pkg::STRING_BASE) begin
							cmd_ctrl.head     = data;
							cmd_ctrl.head_end = 1'b1;
						end else begin
							cmd_ctrl.head     = rlpse_pkg::STRING_BASE + 8'd1;
							cmd_ctrl.tail_end = 1'b1;
							cmd_cnt           = CNT_W'(1);
							cmd_word[0]       = data;
						end
					end else begin
						rem_d             = rem_dec;
						cmd_ctrl.head     = data;
						cmd_ctrl.head_end = (rem_dec == '0);
						open_d            = (rem_dec != '0);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			open_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			rem_q  <= rem_d;
			open_q <= open_d;
			pend_q <= pend_d;
		end
	end

endmodule

>>> hdl/rlpse_queue.sv
module rlpse_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = rlpse_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

>>> hdl/rlpse_back.sv
module rlpse_back #(
	parameter int LEN_BYTES = rlpse_pkg::LEN_BYTES_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_empty,
	output logic                                pop,
	input  rlpse_pkg::cmd_ctrl_t                cmd_ctrl,
	input  logic [$clog2(LEN_BYTES+1)-1:0]      cmd_cnt,
	input  logic [LEN_BYTES-1:0][7:0]           cmd_word,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [rlpse_pkg::OUT_TDATA_W-1:0]   m_tdata,  // out_byte
	output logic                                m_tlast,
	output logic                                m_tuser   // error
);

	localparam int CNT_W = $clog2(LEN_BYTES + 1);
	localparam int IDX_W = (LEN_BYTES > 1) ? $clog2(LEN_BYTES) : 1;

	logic                     out_valid_q;
	logic [7:0]               out_byte_q;
	logic                     out_end_q;
	logic                     out_err_q;
	logic [CNT_W-1:0]         rem_q;
	logic [LEN_BYTES-1:0][7:0] word_q;
	logic                     tail_end_q;

	logic             out_free;
	logic             in_tail;
	logic [CNT_W-1:0] rem_m1;
	logic [IDX_W-1:0] idx;

	assign out_free = !out_valid_q || m_tready;
	assign in_tail  = (rem_q != '0);
	assign rem_m1   = rem_q - CNT_W'(1);
	assign idx      = rem_m1[IDX_W-1:0];
	assign pop      = out_free && !in_tail && !q_empty;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_end_q;
	assign m_tuser  = out_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rem_q       <= '0;
		end else if (out_free) begin
			if (in_tail) begin
				out_valid_q <= 1'b1;
				rem_q       <= rem_m1;
			end else if (!q_empty) begin
				out_valid_q <= 1'b1;
				rem_q       <= cmd_cnt;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// tail bytes go out most significant first
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (in_tail) begin
				out_byte_q <= word_q[idx];
				out_end_q  <= (rem_q == CNT_W'(1)) && tail_end_q;
				out_err_q  <= 1'b0;
			end else if (!q_empty) begin
				out_byte_q <= cmd_ctrl.head;
				out_end_q  <= cmd_ctrl.head_end;
				out_err_q  <= cmd_ctrl.head_err;
				word_q     <= cmd_word;
				tail_end_q <= cmd_ctrl.tail_end;
			end
		end
	end

endmodule

>>> hdl/rlp_stream_encoder.sv
// RLP stream encoder: takes one request per cycle while s_tready is high (start string,
// start list or payload byte on s_tuser) and emits the encoded byte stream, one byte per
// cycle on the master side while m_tready allows, with tlast on the final byte of each
// item and tuser flagging a payload byte that arrived with no item open. A payload byte
// emits one output byte, or two when it completes a one-byte string at 0x80 or above
// (prefix 0x81, then the byte); a start request emits one byte for a short prefix and
// 1 + n bytes for a long one, n being the length-of-length (at most LEN_BYTES). A
// one-byte string emits nothing until its byte arrives. The front classifies requests
// into commands and a four-entry command queue lets the output side work through a long
// header while the input keeps accepting; s_tready drops only while that queue is full.
module rlp_stream_encoder #(
	parameter int LEN_BYTES = rlpse_pkg::LEN_BYTES_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rlpse_pkg::IN_TDATA_W-1:0]  s_tdata,   // payload_length[31:0], data_byte[39:32]
	input  logic [rlpse_pkg::OP_W-1:0]        s_tuser,   // operation[1:0]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rlpse_pkg::OUT_TDATA_W-1:0] m_tdata,   // out_byte[7:0]
	output logic                              m_tlast,
	output logic                              m_tuser    // error[0]
);

	localparam int LEN_W = 8 * LEN_BYTES;
	localparam int CNT_W = $clog2(LEN_BYTES + 1);
	localparam int Q_W   = $bits(rlpse_pkg::cmd_ctrl_t) + CNT_W + LEN_W;
	localparam int QC_W  = $clog2(rlpse_pkg::QUEUE_DEPTH + 1);

	rlpse_pkg::cmd_ctrl_t      f_ctrl, r_ctrl;
	logic [CNT_W-1:0]          f_cnt, r_cnt;
	logic [LEN_BYTES-1:0][7:0] f_word, r_word;
	logic                      q_push, q_pop, q_full, q_empty;
	logic [Q_W-1:0]            q_wdata, q_rdata;
	logic [QC_W-1:0]           q_count;

	rlpse_front #(.LEN_BYTES(LEN_BYTES)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.push     (q_push),
		.cmd_ctrl (f_ctrl),
		.cmd_cnt  (f_cnt),
		.cmd_word (f_word)
	);

	assign q_wdata = {f_cnt, f_word, f_ctrl};
	assign {r_cnt, r_word, r_ctrl} = q_rdata;

	rlpse_queue #(.WIDTH(Q_W), .DEPTH(rlpse_pkg::QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty),
		.count  (q_count)
	);

	rlpse_back #(.LEN_BYTES(LEN_BYTES)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.pop      (q_pop),
		.cmd_ctrl (r_ctrl),
		.cmd_cnt  (r_cnt),
		.cmd_word (r_word),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QC_W'(rlpse_pkg::QUEUE_DEPTH))
		else $error("command queue count out of range");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !m_tlast && m_tdata == '0)
		else $error("error result carries data or end mark");

	a_pop_shows_head: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> m_tvalid && m_tdata == $past(r_ctrl.head))
		else $error("popped command head not presented");

endmodule
